// ----- rtl/vbfc_pkg.sv -----
// vbfc_pkg: shared widths and register indexes of the voxel boundary face color block.
// Standalone package; used by vbfc_store and voxel_boundary_face_color.
package vbfc_pkg;

    localparam int VAL_W     = 8;   // voxel value and face color width
    localparam int SIZE_W    = 7;   // size register width
    localparam int POS_W     = 6;   // reported coordinate width
    localparam int CFG_IDX_W = 2;   // configuration register index width

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_index_t;

endpackage

// ----- rtl/vbfc_store.sv -----
// vbfc_store: single-port read-first voxel store with a registered read port.
// Depends on vbfc_pkg for the value width.
module vbfc_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [AW-1:0]              addr,
    input  logic [vbfc_pkg::VAL_W-1:0] wdata,
    output logic [vbfc_pkg::VAL_W-1:0] rdata
);
    import vbfc_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    // Read the old contents and write the new value in the same cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/voxel_boundary_face_color.sv -----
// voxel_boundary_face_color: left, up and front face colors of a raster-order voxel stream.
// Depends on vbfc_pkg and on vbfc_store (row store and plane store).
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   voxel_value
//   out      output     out_valid/out_stall left_color, up_color, front_color,
//                                           pos_x, pos_y, pos_z, last_voxel
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// One voxel per cycle sustained while the output is not stalled; a result passes the middle
// stage and then the output register. Each voxel makes one read-first access to the row
// store and one to the plane store at the transfer edge, which sets the rate at one voxel
// per cycle. Reset clears the position counters and the pipeline valids and sets all
// sizes to 64; the stores are not cleared, and there is no clearing pass. A stalled
// output holds its register; one more voxel enters the middle stage before the input stalls.
module voxel_boundary_face_color #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [vbfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vbfc_pkg::SIZE_W-1:0]    cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [vbfc_pkg::VAL_W-1:0]     voxel_value,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [vbfc_pkg::VAL_W-1:0]     left_color,
    output logic [vbfc_pkg::VAL_W-1:0]     up_color,
    output logic [vbfc_pkg::VAL_W-1:0]     front_color,
    output logic [vbfc_pkg::POS_W-1:0]     pos_x,
    output logic [vbfc_pkg::POS_W-1:0]     pos_y,
    output logic [vbfc_pkg::POS_W-1:0]     pos_z,
    output logic                           last_voxel
);
    import vbfc_pkg::*;

    // Counter widths and compare widths (wide enough for the size and for x+1).
    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int XE = (XW + 1 > SIZE_W) ? XW + 1 : SIZE_W;
    localparam int YE = (YW + 1 > SIZE_W) ? YW + 1 : SIZE_W;
    localparam int ZE = (ZW + 1 > SIZE_W) ? ZW + 1 : SIZE_W;
    localparam int PDEPTH = MAX_X * MAX_Y;
    localparam int PW = $clog2(PDEPTH);

    // Face color: zero on the boundary or between equal voxels, else the larger.
    function automatic logic [VAL_W-1:0] face_color(input logic boundary,
                                                    input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] res;
        if (boundary || (a == b))
            res = '0;
        else if (a > b)
            res = a;
        else
            res = b;
        return res;
    endfunction

    // Size registers
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    // Position of the next voxel
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;

    logic [VAL_W-1:0] prev_reg;

    // Middle stage: voxel waiting for its store read data
    logic             s1_valid_reg;
    logic [VAL_W-1:0] s1_value_reg;
    logic [VAL_W-1:0] s1_prev_reg;
    logic [XW-1:0]    s1_x_reg;
    logic [YW-1:0]    s1_y_reg;
    logic [ZW-1:0]    s1_z_reg;
    logic             s1_last_reg;

    // Output register
    logic             out_valid_reg;
    logic [VAL_W-1:0] left_reg, up_reg, front_reg;
    logic [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic             last_reg;

    logic [XE-1:0] eff_x;
    logic [YE-1:0] eff_y;
    logic [ZE-1:0] eff_z;
    logic          last_x, last_y, last_z;
    logic          in_xfer, s1_adv;
    logic [PW-1:0] plane_addr;
    logic [VAL_W-1:0] row_rdata, plane_rdata;

    // Clamp sizes: zero acts as one, anything above the maximum acts as the maximum.
    always_comb
    begin
        if (size_x_reg == '0)
            eff_x = XE'(1);
        else if (XE'(size_x_reg) > XE'(MAX_X))
            eff_x = XE'(MAX_X);
        else
            eff_x = XE'(size_x_reg);

        if (size_y_reg == '0)
            eff_y = YE'(1);
        else if (YE'(size_y_reg) > YE'(MAX_Y))
            eff_y = YE'(MAX_Y);
        else
            eff_y = YE'(size_y_reg);

        if (size_z_reg == '0)
            eff_z = ZE'(1);
        else if (ZE'(size_z_reg) > ZE'(MAX_Z))
            eff_z = ZE'(MAX_Z);
        else
            eff_z = ZE'(size_z_reg);
    end

    // A counter at or past its last index wraps on the next advance.
    assign last_x = (XE'(x_reg) + XE'(1)) >= eff_x;
    assign last_y = (YE'(y_reg) + YE'(1)) >= eff_y;
    assign last_z = (ZE'(z_reg) + ZE'(1)) >= eff_z;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (!last_x)
            x_next = x_reg + XW'(1);
        else
        begin
            x_next = '0;
            if (!last_y)
                y_next = y_reg + YW'(1);
            else
            begin
                y_next = '0;
                z_next = last_z ? '0 : z_reg + ZW'(1);
            end
        end
    end

    // Handshake: the middle stage moves on when the output register is free or drains.
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_xfer  = in_valid && !in_stall;

    assign plane_addr = PW'(y_reg) * PW'(MAX_X) + PW'(x_reg);

    // Row and plane stores: read the neighbor and store this voxel at the transfer edge.
    // The read data holds until the next transfer, so it stays with the middle stage.
    vbfc_store #(
        .DEPTH (MAX_X),
        .AW    (XW)
    ) u_row_store (
        .clk   (clk),
        .en    (in_xfer),
        .addr  (x_reg),
        .wdata (voxel_value),
        .rdata (row_rdata)
    );

    vbfc_store #(
        .DEPTH (PDEPTH),
        .AW    (PW)
    ) u_plane_store (
        .clk   (clk),
        .en    (in_xfer),
        .addr  (plane_addr),
        .wdata (voxel_value),
        .rdata (plane_rdata)
    );

    // Configuration writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(64);
            size_y_reg <= SIZE_W'(64);
            size_z_reg <= SIZE_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position counters and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload of the middle stage; the previous voxel value advances with each transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            prev_reg     <= voxel_value;
            s1_value_reg <= voxel_value;
            s1_prev_reg  <= prev_reg;
            s1_x_reg     <= x_reg;
            s1_y_reg     <= y_reg;
            s1_z_reg     <= z_reg;
            s1_last_reg  <= last_x && last_y && last_z;
        end
    end

    // Output payload: face colors from the held store read data.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            left_reg  <= face_color(s1_x_reg == '0, s1_value_reg, s1_prev_reg);
            up_reg    <= face_color(s1_y_reg == '0, s1_value_reg, row_rdata);
            front_reg <= face_color(s1_z_reg == '0, s1_value_reg, plane_rdata);
            pos_x_reg <= POS_W'(s1_x_reg);
            pos_y_reg <= POS_W'(s1_y_reg);
            pos_z_reg <= POS_W'(s1_z_reg);
            last_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_color  = left_reg;
    assign up_color    = up_reg;
    assign front_color = front_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign last_voxel  = last_reg;

    // The x counter never leaves the row store range.
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (XE'(x_reg) < XE'(MAX_X)))
        else $error("x counter out of range");

    // A transferred voxel lands in the middle stage.
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("transferred voxel lost before middle stage");

    // A voxel that leaves the middle stage shows up at the output.
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv) |=> out_valid_reg)
        else $error("middle stage result lost");

    // A held middle stage keeps its voxel while the output is stalled.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_value_reg)))
        else $error("middle stage changed while stalled");

endmodule
